>>> design/cst_pkg.sv
// Package for the capture slot tracker: slot states, operation and result codes.
// No dependencies.
package cst_pkg;

    typedef enum logic [2:0] {
        SLOT_IDLE      = 3'd0,
        SLOT_RESERVED  = 3'd1,
        SLOT_SUBMITTED = 3'd2,
        SLOT_FAILED    = 3'd3,
        SLOT_READY     = 3'd4,
        SLOT_ACQUIRED  = 3'd5,
        SLOT_ABANDONED = 3'd6
    } slot_state_t;

    localparam logic [2:0] OP_RESERVE = 3'd0;
    localparam logic [2:0] OP_SUBMIT  = 3'd1;
    localparam logic [2:0] OP_FAIL    = 3'd2;
    localparam logic [2:0] OP_COLLECT = 3'd3;
    localparam logic [2:0] OP_POLL    = 3'd4;
    localparam logic [2:0] OP_RELEASE = 3'd5;

    localparam logic [3:0] RC_OK        = 4'd0;
    localparam logic [3:0] RC_INVALID   = 4'd1;
    localparam logic [3:0] RC_OOM       = 4'd2;
    localparam logic [3:0] RC_BUSY      = 4'd3;
    localparam logic [3:0] RC_REJECTED  = 4'd4;
    localparam logic [3:0] RC_NOT_FOUND = 4'd5;
    localparam logic [3:0] RC_FAILED    = 4'd6;
    localparam logic [3:0] RC_READY     = 4'd7;
    localparam logic [3:0] RC_PENDING   = 4'd8;

    localparam logic [1:0] CFG_RING_ENABLED = 2'd0;
    localparam logic [1:0] CFG_SLOTS_IN_USE = 2'd1;
    localparam logic [1:0] CFG_MAX_BATCH    = 2'd2;

    typedef enum logic [1:0] {
        FSM_IDLE  = 2'd0,
        FSM_SCAN  = 2'd1,
        FSM_APPLY = 2'd2,
        FSM_OUT   = 2'd3
    } fsm_state_t;

    // One slot record as it travels around the ring of cells
    typedef struct packed {
        slot_state_t  state;
        logic [31:0]  request;
        logic [31:0]  frame;
        logic [4:0]   items;
        logic [47:0]  serial;
        logic [3:0]   error;
    } slot_rec_t;

    // Command from the sequencer to every cell
    typedef struct packed {
        logic        rotate;   // shift records one cell toward the head
        logic        active;   // head record lies below the effective count
        logic        sweep;    // apply collect to the head record
        logic        write;    // pass wr_rec on in place of the head record
        slot_rec_t   wr_rec;
        logic [47:0] done;
    } cell_cmd_t;

endpackage

>>> design/cst_cell.sv
// One slot cell of the rotating slot ring: holds a record, passes it on.
// Depends on cst_pkg.
module cst_cell
    import cst_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  cell_cmd_t cmd,
    input  logic      is_head,
    input  slot_rec_t rec_in,
    output slot_rec_t rec_out
);

    slot_rec_t rec_reg;
    slot_rec_t rec_next;
    slot_rec_t swept;

    // Collect on the record passing the head
    always_comb begin
        swept = rec_reg;
        if (cmd.sweep && cmd.active && rec_reg.serial != 48'd0
                && rec_reg.serial <= cmd.done) begin
            if (rec_reg.state == SLOT_ABANDONED) begin
                swept = '0;
            end else if (rec_reg.state == SLOT_SUBMITTED) begin
                swept.state = SLOT_READY;
            end
        end
    end

    // Advance on rotate, otherwise hold
    always_comb begin
        rec_next = rec_reg;
        if (cmd.rotate) begin
            rec_next = rec_in;
        end
    end

    // The head hands on the written record in place of its own when writing
    assign rec_out = !is_head ? rec_reg : (cmd.write ? cmd.wr_rec : swept);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rec_reg <= '0;
        end else begin
            rec_reg <= rec_next;
        end
    end

endmodule

>>> design/cst_ctrl.sv
// Sequencer: walks the head of the slot ring past each slot, decides results.
// Depends on cst_pkg.
module cst_ctrl
    import cst_pkg::*;
#(
    parameter int SLOT_COUNT = 8,
    parameter int MAX_ITEMS  = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        ring_enabled,
    input  logic [3:0]  slots_in_use,
    input  logic [31:0] batch_limit,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_operation,
    input  logic [31:0] s_request_id,
    input  logic [4:0]  s_item_count,
    input  logic [31:0] s_batch_bytes,
    input  logic        s_plan_invalid,
    input  logic [31:0] s_frame_index,
    input  logic [47:0] s_serial,
    input  logic        s_staging_present,
    input  logic [3:0]  s_error_code,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [3:0]  m_result_code,
    output logic [3:0]  m_found_error,
    output logic [4:0]  m_found_items,
    output logic [31:0] m_found_frame,
    output logic [47:0] m_found_serial,
    input  slot_rec_t   head_rec,
    output cell_cmd_t   cmd
);

    localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CW = $clog2(SLOT_COUNT + 1);
    localparam int SW = (CW > 4) ? CW : 4;

    fsm_state_t  state_reg, state_next;
    logic [CW-1:0] pos_reg, pos_next;
    logic [2:0]  op_reg;
    logic [31:0] id_reg, frame_reg, bytes_reg;
    logic [4:0]  items_reg;
    logic        bad_reg, stage_reg;
    logic [47:0] serial_reg;
    logic [3:0]  err_reg;
    logic        hit_reg, hit_next, idle_reg, idle_next;
    logic [IW-1:0] hit_idx_reg, hit_idx_next, idle_idx_reg, idle_idx_next;
    slot_rec_t   hit_rec_reg, hit_rec_next;
    logic [31:0] last_reg, last_next;
    logic [3:0]  rc_reg, rc_next;
    slot_rec_t   out_rec_reg, out_rec_next;
    logic        wr_en;
    slot_rec_t   wr_rec;
    logic [SW-1:0] eff_count;
    logic        head_active;
    logic        is_sweep;
    logic        bad_items;

    // Effective slot count, clamped to the built count
    always_comb begin
        if (SW'(slots_in_use) > SW'(SLOT_COUNT)) begin
            eff_count = SW'(SLOT_COUNT);
        end else begin
            eff_count = SW'(slots_in_use);
        end
    end

    assign head_active = SW'(pos_reg) < eff_count;
    assign is_sweep = ring_enabled && (op_reg == OP_COLLECT ||
                      (op_reg == OP_POLL && id_reg != 32'd0));
    assign bad_items = items_reg == 5'd0 || 32'(items_reg) > 32'(MAX_ITEMS);

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            FSM_IDLE:  if (s_valid) state_next = FSM_SCAN;
            FSM_SCAN:  if (pos_reg == CW'(SLOT_COUNT - 1)) state_next = FSM_APPLY;
            FSM_APPLY: state_next = FSM_OUT;
            FSM_OUT:   if (m_ready) state_next = FSM_IDLE;
            default:   state_next = FSM_IDLE;
        endcase
    end

    // Scan: note first match and first idle slot as each slot passes the head
    always_comb begin
        pos_next = pos_reg;
        hit_next = hit_reg;
        hit_idx_next = hit_idx_reg;
        hit_rec_next = hit_rec_reg;
        idle_next = idle_reg;
        idle_idx_next = idle_idx_reg;
        if (state_reg == FSM_IDLE) begin
            pos_next = '0;
            hit_next = 1'b0;
            idle_next = 1'b0;
        end else if (state_reg == FSM_SCAN) begin
            pos_next = (pos_reg == CW'(SLOT_COUNT - 1)) ? '0 : pos_reg + 1'b1;
            if (head_active && !hit_reg && head_rec.state != SLOT_IDLE
                    && head_rec.request == id_reg) begin
                hit_next = 1'b1;
                hit_idx_next = IW'(pos_reg);
                hit_rec_next = head_rec;
            end
            if (head_active && !idle_reg && head_rec.state == SLOT_IDLE) begin
                idle_next = 1'b1;
                idle_idx_next = IW'(pos_reg);
            end
        end
    end

    // Decide result and head write during the apply cycle
    always_comb begin
        rc_next = rc_reg;
        out_rec_next = out_rec_reg;
        last_next = last_reg;
        wr_en = 1'b0;
        wr_rec = hit_rec_reg;
        if (state_reg == FSM_APPLY) begin
            out_rec_next = '0;
            case (op_reg)
                OP_RESERVE: begin
                    if (!ring_enabled || id_reg <= last_reg || bad_items || hit_reg
                            || bad_reg) begin
                        rc_next = RC_INVALID;
                    end else if (bytes_reg > batch_limit) begin
                        rc_next = RC_OOM;
                    end else if (!idle_reg) begin
                        rc_next = RC_BUSY;
                    end else begin
                        rc_next = RC_OK;
                        wr_en = 1'b1;
                        wr_rec = '0;
                        wr_rec.state = SLOT_RESERVED;
                        wr_rec.request = id_reg;
                        wr_rec.frame = frame_reg;
                        wr_rec.items = items_reg;
                        last_next = id_reg;
                    end
                end
                OP_SUBMIT: begin
                    if (!hit_reg || hit_rec_reg.state != SLOT_RESERVED
                            || serial_reg == 48'd0 || !stage_reg) begin
                        rc_next = RC_REJECTED;
                    end else begin
                        rc_next = RC_OK;
                        wr_en = 1'b1;
                        wr_rec.state = SLOT_SUBMITTED;
                        wr_rec.serial = serial_reg;
                    end
                end
                OP_FAIL: begin
                    if (!hit_reg || hit_rec_reg.state != SLOT_RESERVED
                            || err_reg == 4'd0) begin
                        rc_next = RC_REJECTED;
                    end else begin
                        rc_next = RC_OK;
                        wr_en = 1'b1;
                        wr_rec.state = SLOT_FAILED;
                        wr_rec.error = err_reg;
                    end
                end
                OP_COLLECT: rc_next = RC_OK;
                OP_POLL: begin
                    if (!hit_reg || hit_rec_reg.state == SLOT_ABANDONED) begin
                        rc_next = RC_NOT_FOUND;
                    end else begin
                        out_rec_next = hit_rec_reg;
                        if (hit_rec_reg.state == SLOT_FAILED) begin
                            rc_next = RC_FAILED;
                        end else if (hit_rec_reg.state == SLOT_READY
                                || hit_rec_reg.state == SLOT_ACQUIRED) begin
                            rc_next = RC_READY;
                            wr_en = 1'b1;
                            wr_rec.state = SLOT_ACQUIRED;
                        end else begin
                            rc_next = RC_PENDING;
                        end
                    end
                end
                OP_RELEASE: begin
                    if (!hit_reg) begin
                        rc_next = RC_REJECTED;
                    end else begin
                        rc_next = RC_OK;
                        wr_en = 1'b1;
                        if (hit_rec_reg.state == SLOT_SUBMITTED) begin
                            wr_rec.state = SLOT_ABANDONED;
                        end else begin
                            wr_rec = '0;
                        end
                    end
                end
                default: rc_next = RC_INVALID;
            endcase
        end
    end

    // Cell command: after apply the ring is back at slot 0; a second rotation
    // pass substitutes the new record as the target slot leaves the head.
    logic [IW-1:0] tgt_idx;
    assign tgt_idx = (op_reg == OP_RESERVE) ? idle_idx_reg : hit_idx_reg;

    logic          wb_pending_reg, wb_pending_next;
    slot_rec_t     wb_rec_reg, wb_rec_next;
    logic [IW-1:0] wb_idx_reg, wb_idx_next;
    logic [CW-1:0] wb_pos_reg, wb_pos_next;

    // Writeback pass runs during the output phase: rotate once round the ring
    always_comb begin
        wb_pending_next = wb_pending_reg;
        wb_rec_next = wb_rec_reg;
        wb_idx_next = wb_idx_reg;
        wb_pos_next = wb_pos_reg;
        if (state_reg == FSM_APPLY) begin
            wb_pending_next = wr_en;
            wb_rec_next = wr_rec;
            wb_idx_next = tgt_idx;
            wb_pos_next = '0;
        end else if (wb_pending_reg) begin
            wb_pos_next = (wb_pos_reg == CW'(SLOT_COUNT - 1)) ? '0 : wb_pos_reg + 1'b1;
            if (wb_pos_reg == CW'(SLOT_COUNT - 1)) begin
                wb_pending_next = 1'b0;
            end
        end
    end

    always_comb begin
        cmd = '0;
        cmd.done = serial_reg;
        cmd.active = head_active;
        if (state_reg == FSM_SCAN) begin
            cmd.rotate = 1'b1;
            cmd.sweep = is_sweep;
        end else if (wb_pending_reg) begin
            cmd.rotate = 1'b1;
            cmd.write = IW'(wb_pos_reg) == wb_idx_reg;
            cmd.wr_rec = wb_rec_reg;
        end
    end

    // Hold a new item until the writeback pass is finished
    assign s_ready = state_reg == FSM_IDLE && !wb_pending_reg;
    assign m_valid = state_reg == FSM_OUT;
    assign m_result_code = rc_reg;
    assign m_found_error = out_rec_reg.error;
    assign m_found_items = out_rec_reg.items;
    assign m_found_frame = out_rec_reg.frame;
    assign m_found_serial = out_rec_reg.serial;

    // Sequencer registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= FSM_IDLE;
            pos_reg <= '0;
            hit_reg <= 1'b0;
            idle_reg <= 1'b0;
            last_reg <= '0;
            wb_pending_reg <= 1'b0;
            wb_pos_reg <= '0;
        end else begin
            if (state_reg == FSM_IDLE && !s_ready) begin
                state_reg <= FSM_IDLE;
            end else begin
                state_reg <= state_next;
            end
            pos_reg <= pos_next;
            hit_reg <= hit_next;
            idle_reg <= idle_next;
            last_reg <= last_next;
            wb_pending_reg <= wb_pending_next;
            wb_pos_reg <= wb_pos_next;
        end
    end

    // Captured item and scan results
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            op_reg <= s_operation;
            id_reg <= s_request_id;
            items_reg <= s_item_count;
            bytes_reg <= s_batch_bytes;
            bad_reg <= s_plan_invalid;
            frame_reg <= s_frame_index;
            serial_reg <= s_serial;
            stage_reg <= s_staging_present;
            err_reg <= s_error_code;
        end
        hit_idx_reg <= hit_idx_next;
        hit_rec_reg <= hit_rec_next;
        idle_idx_reg <= idle_idx_next;
        rc_reg <= rc_next;
        out_rec_reg <= out_rec_next;
        wb_rec_reg <= wb_rec_next;
        wb_idx_reg <= wb_idx_next;
    end

endmodule

>>> design/capture_slot_tracker.sv
// Capture slot tracker top level: configuration, sequencer and slot ring.
// Depends on cst_pkg, cst_ctrl and cst_cell.
//
//   channel   prefix  direction  content
//   request   s_      in         operation, ids, batch info, serial, error code
//   result    m_      out        result code and fields of the polled slot
//   config    cfg_    in         write enable, register index, write data
//
// A result is offered after its input transfer once one scan rotation of the slot
// ring, the decision in the apply state and the output register are passed.
// A state change is written back by a second rotation of the ring, which
// overlaps the output phase; the next item is taken once that pass ends, and
// no new item is taken while an earlier one is still in the sequencer.
// Reset (aresetn low, synchronous) idles all slots and restores register defaults.
// A stalled result holds in the output register; s_ready stays low meanwhile.
module capture_slot_tracker
    import cst_pkg::*;
#(
    parameter int SLOT_COUNT = 8,
    parameter int MAX_ITEMS  = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_operation,
    input  logic [31:0] s_request_id,
    input  logic [4:0]  s_item_count,
    input  logic [31:0] s_batch_bytes,
    input  logic        s_plan_invalid,
    input  logic [31:0] s_frame_index,
    input  logic [47:0] s_serial,
    input  logic        s_staging_present,
    input  logic [3:0]  s_error_code,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [3:0]  m_result_code,
    output logic [3:0]  m_found_error,
    output logic [4:0]  m_found_items,
    output logic [31:0] m_found_frame,
    output logic [47:0] m_found_serial
);

    logic        ring_enabled_reg;
    logic [3:0]  slots_in_use_reg;
    logic [31:0] max_batch_reg;
    cell_cmd_t   cmd;
    slot_rec_t   ring [SLOT_COUNT];

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ring_enabled_reg <= 1'b0;
            slots_in_use_reg <= 4'd8;
            max_batch_reg <= 32'd65536;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_RING_ENABLED: ring_enabled_reg <= cfg_data[0];
                CFG_SLOTS_IN_USE: slots_in_use_reg <= cfg_data[3:0];
                CFG_MAX_BATCH:    max_batch_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    cst_ctrl #(.SLOT_COUNT(SLOT_COUNT), .MAX_ITEMS(MAX_ITEMS)) u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .ring_enabled(ring_enabled_reg), .slots_in_use(slots_in_use_reg),
        .batch_limit(max_batch_reg),
        .s_valid(s_valid), .s_ready(s_ready), .s_operation(s_operation),
        .s_request_id(s_request_id), .s_item_count(s_item_count),
        .s_batch_bytes(s_batch_bytes), .s_plan_invalid(s_plan_invalid),
        .s_frame_index(s_frame_index), .s_serial(s_serial),
        .s_staging_present(s_staging_present), .s_error_code(s_error_code),
        .m_valid(m_valid), .m_ready(m_ready), .m_result_code(m_result_code),
        .m_found_error(m_found_error), .m_found_items(m_found_items),
        .m_found_frame(m_found_frame), .m_found_serial(m_found_serial),
        .head_rec(ring[0]), .cmd(cmd)
    );

    // Ring of cells; cell 0 is the head, records move toward lower indexes
    for (genvar i = 0; i < SLOT_COUNT; i++) begin : g_cell
        cst_cell u_cell (
            .aclk(aclk), .aresetn(aresetn), .cmd(cmd),
            .is_head(i == 0),
            .rec_in(ring[(i + 1) % SLOT_COUNT]),
            .rec_out(ring[i])
        );
    end

    // Result is held while stalled
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_result_code))
        else $error("result changed while stalled");

    // No new item while a result is waiting
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready)
        else $error("input ready during result phase");

    // Result codes stay within the defined set
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_result_code <= RC_PENDING)
        else $error("undefined result code");

endmodule

>>> tb/tb_top.sv
// Testbench for capture_slot_tracker: directed and random slot operations,
// checked against a behavioral slot table held in a scoreboard class.
// Depends on cst_pkg and the capture_slot_tracker RTL.
module tb_top
    import cst_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NSLOT = 8;
    localparam int NITEM = 16;

    typedef struct packed {
        logic [2:0]  op;
        logic [31:0] id;
        logic [4:0]  items;
        logic [31:0] bytes;
        logic        bad_plan;
        logic [31:0] frame;
        logic [47:0] serial;
        logic        staging;
        logic [3:0]  err;
    } request_t;

    typedef struct packed {
        logic [3:0]  rc;
        logic [3:0]  err;
        logic [4:0]  items;
        logic [31:0] frame;
        logic [47:0] serial;
    } answer_t;

    // Slot table model plus the queue of answers still owed by the block
    class slot_scoreboard;
        slot_state_t st[NSLOT];
        logic [31:0] req[NSLOT];
        logic [31:0] frm[NSLOT];
        logic [4:0]  itm[NSLOT];
        logic [47:0] ser[NSLOT];
        logic [3:0]  er[NSLOT];
        logic [31:0] last_id;
        logic        ring_on;
        logic [3:0]  slots_cfg;
        logic [31:0] max_bytes;
        answer_t     owed[$];
        int          errors;

        function void reset_table();
            for (int i = 0; i < NSLOT; i++) clear_slot(i);
            last_id = '0;
            ring_on = 1'b0;
            slots_cfg = 4'd8;
            max_bytes = 32'd65536;
        endfunction

        function void clear_slot(int i);
            st[i] = SLOT_IDLE;
            req[i] = '0;
            frm[i] = '0;
            itm[i] = '0;
            ser[i] = '0;
            er[i] = '0;
        endfunction

        function int span();
            return (slots_cfg > NSLOT) ? NSLOT : int'(slots_cfg);
        endfunction

        function int lookup(logic [31:0] id);
            for (int i = 0; i < span(); i++)
                if (st[i] != SLOT_IDLE && req[i] == id) return i;
            return -1;
        endfunction

        function void collect(logic [47:0] done);
            if (!ring_on) return;
            for (int i = 0; i < span(); i++) begin
                if ((st[i] == SLOT_SUBMITTED || st[i] == SLOT_ABANDONED) &&
                    ser[i] != 0 && ser[i] <= done) begin
                    if (st[i] == SLOT_ABANDONED) clear_slot(i);
                    else st[i] = SLOT_READY;
                end
            end
        endfunction

        function void write_reg(logic [1:0] idx, logic [31:0] val);
            case (idx)
                CFG_RING_ENABLED: ring_on = val[0];
                CFG_SLOTS_IN_USE: slots_cfg = val[3:0];
                CFG_MAX_BATCH:    max_bytes = val;
                default: ;
            endcase
        endfunction

        // Apply one accepted request and queue the answer it owes
        function void note_request(request_t r);
            answer_t a;
            int k;
            a = '0;
            a.rc = RC_INVALID;
            case (r.op)
                OP_RESERVE: begin
                    if (!ring_on || r.id <= last_id || r.items == 0 || r.items > NITEM ||
                        lookup(r.id) >= 0 || r.bad_plan)
                        a.rc = RC_INVALID;
                    else if (r.bytes > max_bytes)
                        a.rc = RC_OOM;
                    else begin
                        a.rc = RC_BUSY;
                        for (int i = 0; i < span(); i++) begin
                            if (st[i] == SLOT_IDLE) begin
                                clear_slot(i);
                                st[i] = SLOT_RESERVED;
                                req[i] = r.id;
                                frm[i] = r.frame;
                                itm[i] = r.items;
                                last_id = r.id;
                                a.rc = RC_OK;
                                break;
                            end
                        end
                    end
                end
                OP_SUBMIT: begin
                    k = lookup(r.id);
                    if (k < 0 || st[k] != SLOT_RESERVED || r.serial == 0 || !r.staging)
                        a.rc = RC_REJECTED;
                    else begin
                        st[k] = SLOT_SUBMITTED;
                        ser[k] = r.serial;
                        a.rc = RC_OK;
                    end
                end
                OP_FAIL: begin
                    k = lookup(r.id);
                    if (k < 0 || st[k] != SLOT_RESERVED || r.err == 0)
                        a.rc = RC_REJECTED;
                    else begin
                        st[k] = SLOT_FAILED;
                        er[k] = r.err;
                        a.rc = RC_OK;
                    end
                end
                OP_COLLECT: begin
                    collect(r.serial);
                    a.rc = RC_OK;
                end
                OP_POLL: begin
                    a.rc = RC_NOT_FOUND;
                    if (r.id != 0) begin
                        collect(r.serial);
                        k = lookup(r.id);
                        if (k >= 0 && st[k] != SLOT_ABANDONED) begin
                            a.err = er[k];
                            a.items = itm[k];
                            a.frame = frm[k];
                            a.serial = ser[k];
                            if (st[k] == SLOT_FAILED) a.rc = RC_FAILED;
                            else if (st[k] == SLOT_READY || st[k] == SLOT_ACQUIRED) begin
                                st[k] = SLOT_ACQUIRED;
                                a.rc = RC_READY;
                            end else a.rc = RC_PENDING;
                        end
                    end
                end
                OP_RELEASE: begin
                    k = lookup(r.id);
                    if (k < 0) a.rc = RC_REJECTED;
                    else begin
                        if (st[k] == SLOT_SUBMITTED) st[k] = SLOT_ABANDONED;
                        else clear_slot(k);
                        a.rc = RC_OK;
                    end
                end
                default: a.rc = RC_INVALID;
            endcase
            owed.push_back(a);
        endfunction

        function void check_answer(answer_t got);
            answer_t exp;
            if (owed.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
                return;
            end
            exp = owed.pop_front();
            if (got.rc !== exp.rc) begin
                $display("%0t: result_code exp %0d got %0d", $time, exp.rc, got.rc);
                errors++;
            end
            if (got.err !== exp.err) begin
                $display("%0t: found_error exp %0d got %0d", $time, exp.err, got.err);
                errors++;
            end
            if (got.items !== exp.items) begin
                $display("%0t: found_items exp %0d got %0d", $time, exp.items, got.items);
                errors++;
            end
            if (got.frame !== exp.frame) begin
                $display("%0t: found_frame exp %h got %h", $time, exp.frame, got.frame);
                errors++;
            end
            if (got.serial !== exp.serial) begin
                $display("%0t: found_serial exp %h got %h", $time, exp.serial, got.serial);
                errors++;
            end
        endfunction
    endclass

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        cfg_we = 0;
    logic [1:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;
    logic        s_valid = 0;
    logic        s_ready;
    request_t    req_bus = '0;
    logic        m_valid;
    logic        m_ready = 0;
    answer_t     ans_bus;

    slot_scoreboard board;
    logic  calm = 0;            // no idling in the closing stretch
    logic [31:0] issued_ids[$];
    logic [31:0] next_id = 1;
    logic [47:0] serial_base = 1;

    always #2 aclk = ~aclk;

    capture_slot_tracker dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_operation(req_bus.op), .s_request_id(req_bus.id),
        .s_item_count(req_bus.items), .s_batch_bytes(req_bus.bytes),
        .s_plan_invalid(req_bus.bad_plan), .s_frame_index(req_bus.frame),
        .s_serial(req_bus.serial), .s_staging_present(req_bus.staging),
        .s_error_code(req_bus.err),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_result_code(ans_bus.rc), .m_found_error(ans_bus.err),
        .m_found_items(ans_bus.items), .m_found_frame(ans_bus.frame),
        .m_found_serial(ans_bus.serial)
    );

    // Check each result transfer
    always @(posedge aclk)
        if (aresetn && m_valid && m_ready) board.check_answer(ans_bus);

    // Result side: random stall bursts unless in the closing stretch
    initial begin
        int n;
        @(posedge aclk);
        forever begin
            if (!calm && $urandom_range(0, 3) == 0) begin
                m_ready <= 0;
                n = $urandom_range(1, 17);
                repeat (n) @(posedge aclk);
            end
            m_ready <= 1;
            n = $urandom_range(1, 30);
            repeat (n) @(posedge aclk);
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        cfg_we <= 0;
        board.write_reg(idx, val);
        @(posedge aclk);
    endtask

    // Drive one request and hold it until the transfer; valid drops only for idling
    task automatic send(request_t r);
        int n;
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_valid <= 0;
            n = $urandom_range(1, 17);
            repeat (n) @(posedge aclk);
        end
        s_valid <= 1;
        req_bus <= r;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        board.note_request(r);
    endtask

    task automatic drain();
        s_valid <= 0;
        while (board.owed.size() != 0) @(posedge aclk);
        repeat (30) @(posedge aclk);
    endtask

    function automatic request_t noise();
        request_t r;
        r = '0;
        r.op = 3'($urandom_range(0, 7));
        r.id = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 40);
        r.items = 5'($urandom_range(0, 31));
        r.bytes = $urandom;
        r.bad_plan = 1'($urandom_range(0, 1));
        r.frame = $urandom;
        r.serial = 48'({$urandom, $urandom});
        r.staging = 1'($urandom_range(0, 1));
        r.err = 4'($urandom_range(0, 15));
        return r;
    endfunction

    function automatic logic [31:0] known_id();
        if (issued_ids.size() == 0) return next_id;
        return issued_ids[$urandom_range(0, issued_ids.size() - 1)];
    endfunction

    // Mostly well-formed lifecycle steps with random content
    function automatic request_t lifecycle();
        request_t r;
        r = noise();
        r.op = 3'($urandom_range(0, 5));
        r.bad_plan = ($urandom_range(0, 15) == 0);
        r.err = 4'($urandom_range(0, 15));
        r.staging = ($urandom_range(0, 9) != 0);
        r.items = $urandom_range(0, 10) == 0 ? 5'($urandom_range(0, 31))
                                             : 5'($urandom_range(1, NITEM));
        r.bytes = $urandom_range(0, 70000);
        case (r.op)
            OP_RESERVE: begin
                if ($urandom_range(0, 9) != 0) begin
                    next_id = next_id + $urandom_range(1, 3);
                    r.id = next_id;
                    issued_ids.push_back(r.id);
                    if (issued_ids.size() > 24) void'(issued_ids.pop_front());
                end else r.id = known_id();
            end
            OP_SUBMIT: begin
                r.id = known_id();
                r.serial = serial_base + $urandom_range(0, 20);
                if ($urandom_range(0, 15) == 0) r.serial = 0;
            end
            default: begin
                r.id = known_id();
                serial_base = serial_base + $urandom_range(0, 4);
                r.serial = serial_base + $urandom_range(0, 10) - 5;
            end
        endcase
        return r;
    endfunction

    initial begin
        request_t r;
        board = new();
        board.reset_table();
        repeat (3) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // Reserve with the ring disabled, then bring the ring up
        r = lifecycle();
        r.op = OP_RESERVE; r.id = 5; r.items = 5'd1; r.bad_plan = 0; r.bytes = 0;
        send(r);
        drain();
        write_reg(CFG_RING_ENABLED, 1);
        write_reg(CFG_MAX_BATCH, 0);

        // Directed: extremes, rejections and one full lifecycle
        r = '0; r.op = OP_RESERVE; r.id = 2; r.items = 5'(NITEM); r.bytes = 1; r.frame = '1;
        send(r);                                   // out of memory with zero limit
        r.bytes = 0; send(r);                      // zero batch fits
        r.id = 2; send(r);                         // id not rising
        r.id = 3; r.items = 5'd0; send(r);         // zero items
        r.items = 5'd17; send(r);                  // too many items
        r.items = 5'h1f; send(r);
        r.items = 5'd1; r.bad_plan = 1; send(r);   // invalid plan
        r.bad_plan = 0; r.frame = 32'h1234; send(r);
        r = '0; r.op = OP_SUBMIT; r.id = 2; r.serial = 0; r.staging = 1; send(r);
        r.serial = '1; r.staging = 0; send(r);
        r.staging = 1; send(r);
        r.op = OP_POLL; r.serial = 48'h10; send(r); // pending
        r.serial = '1; send(r);                     // ready
        send(r);                                    // acquired
        r = '0; r.op = OP_FAIL; r.id = 3; send(r);  // zero error code
        r.err = 4'hf; send(r);
        r.op = OP_POLL; send(r);
        r.id = 0; send(r);
        r = '0; r.op = OP_RELEASE; r.id = 99; send(r);
        r.id = 3; send(r);
        r.op = 3'd6; send(r);
        r.op = 3'd7; r.id = '1; send(r);
        r = '0; r.op = OP_COLLECT; r.serial = '1; send(r);
        drain();

        // Random phases over several register settings
        for (int ph = 0; ph < 7; ph++) begin
            case (ph)
                0: begin
                    write_reg(CFG_SLOTS_IN_USE, 8);
                    write_reg(CFG_MAX_BATCH, 32'hffff_ffff);
                end
                1: write_reg(CFG_SLOTS_IN_USE, 1);
                2: begin
                    write_reg(CFG_SLOTS_IN_USE, 0);
                    write_reg(CFG_MAX_BATCH, 1);
                end
                3: begin
                    write_reg(CFG_SLOTS_IN_USE, 15);
                    write_reg(CFG_MAX_BATCH, 65536);
                end
                4: begin
                    write_reg(CFG_RING_ENABLED, 0);
                    write_reg(CFG_SLOTS_IN_USE, 3);
                end
                5: begin
                    write_reg(CFG_RING_ENABLED, 1);
                    write_reg(CFG_SLOTS_IN_USE, 8);
                end
                default: begin
                    write_reg(CFG_SLOTS_IN_USE, $urandom_range(1, 8));
                    calm = 1;
                end
            endcase
            repeat (ph == 2 || ph == 4 ? 40 : 110) begin
                if ($urandom_range(0, 4) == 0) send(noise());
                else send(lifecycle());
            end
            drain();
        end

        if (board.errors == 0 && board.owed.size() == 0) $display("Verification passed");
        else $display("Verification failed");
        $finish;
    end

    initial begin
        #4ms;
        $display("Verification failed");
        $finish;
    end
endmodule

>>> files.f
design/cst_pkg.sv
design/cst_cell.sv
design/cst_ctrl.sv
design/capture_slot_tracker.sv
tb/tb_top.sv
